// ===== rtl/core/irn_pkg.sv =====
package irn_pkg;

    // result status codes
    localparam logic [1:0] ST_CHAR  = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [11:0] ROMAN_LIMIT = 12'd3999;

    // letter roles inside one decimal position
    localparam logic [1:0] SYM_ONE  = 2'd0;
    localparam logic [1:0] SYM_FIVE = 2'd1;
    localparam logic [1:0] SYM_TEN  = 2'd2;

    // decimal position codes
    localparam logic [1:0] POS_UNITS = 2'd0;
    localparam logic [1:0] POS_TENS  = 2'd1;
    localparam logic [1:0] POS_HUNDS = 2'd2;
    localparam logic [1:0] POS_THOUS = 2'd3;

    localparam logic [7:0] ASCII_I = 8'h49;
    localparam logic [7:0] ASCII_V = 8'h56;
    localparam logic [7:0] ASCII_X = 8'h58;
    localparam logic [7:0] ASCII_L = 8'h4C;
    localparam logic [7:0] ASCII_C = 8'h43;
    localparam logic [7:0] ASCII_D = 8'h44;
    localparam logic [7:0] ASCII_M = 8'h4D;

    localparam int IRN_QUEUE_DEPTH = 4;

    // one classified input, handed from front to back
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] thous;
        logic [3:0] hunds;
        logic [3:0] tens;
        logic [3:0] units;
    } t_item;

    // count of multiples of step not above v (0..9), parallel compares
    function automatic logic [3:0] dec_digit(input logic [11:0] v, input logic [11:0] step);
        logic [3:0]  n;
        logic [15:0] lim;
        n = '0;
        for (int k = 1; k <= 9; k++) begin
            lim = 16'(k) * 16'(step);
            if ({4'b0, v} >= lim) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // number of letters a digit expands to
    function automatic logic [2:0] pat_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // letter role at slot idx of a digit's pattern
    function automatic logic [1:0] pat_sym(input logic [3:0] d, input logic [1:0] idx);
        logic [1:0] s;
        case (d)
            4'd4:    s = (idx == 2'd0) ? SYM_ONE : SYM_FIVE;
            4'd9:    s = (idx == 2'd0) ? SYM_ONE : SYM_TEN;
            4'd5, 4'd6, 4'd7, 4'd8:
                     s = (idx == 2'd0) ? SYM_FIVE : SYM_ONE;
            default: s = SYM_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] letter(input logic [1:0] pos, input logic [1:0] sym);
        logic [7:0] c;
        case (pos)
            POS_UNITS: c = (sym == SYM_ONE) ? ASCII_I : (sym == SYM_FIVE) ? ASCII_V : ASCII_X;
            POS_TENS:  c = (sym == SYM_ONE) ? ASCII_X : (sym == SYM_FIVE) ? ASCII_L : ASCII_C;
            POS_HUNDS: c = (sym == SYM_ONE) ? ASCII_C : (sym == SYM_FIVE) ? ASCII_D : ASCII_M;
            default:   c = ASCII_M;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/irn_front.sv =====
module irn_front
    import irn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_value,
    output logic        o_push,
    input  logic        i_push_ready,
    output t_item       o_item
);

    logic        r1_valid;
    logic [1:0]  r1_status;
    logic [1:0]  r1_thous;
    logic [9:0]  r1_rem;
    logic        r2_valid;
    logic [1:0]  r2_status;
    logic [1:0]  r2_thous;
    logic [3:0]  r2_hunds;
    logic [6:0]  r2_rem;

    logic        s1_ready;
    logic        s2_ready;
    logic [1:0]  n1_status;
    logic [3:0]  n1_thous_full;
    logic [1:0]  n1_thous;
    logic [11:0] n1_rem;
    logic [3:0]  n2_hunds;
    logic [11:0] n2_rem;
    logic [3:0]  n_tens;
    logic [11:0] n_units;

    assign o_push   = r2_valid;
    assign s2_ready = !r2_valid || i_push_ready;
    assign s1_ready = !r1_valid || s2_ready;
    assign o_ready  = s1_ready;

    // stage 1: classify, thousands digit
    always_comb begin
        if (i_value == 12'd0) begin
            n1_status = ST_ZERO;
        end else if (i_value > ROMAN_LIMIT) begin
            n1_status = ST_RANGE;
        end else begin
            n1_status = ST_CHAR;
        end
        n1_thous_full = dec_digit(i_value, 12'd1000);
        n1_thous      = n1_thous_full[1:0];
        n1_rem        = i_value - 12'(16'(n1_thous) * 16'd1000);
    end

    // stage 2: hundreds digit
    always_comb begin
        n2_hunds = dec_digit({2'b0, r1_rem}, 12'd100);
        n2_rem   = {2'b0, r1_rem} - 12'(16'(n2_hunds) * 16'd100);
    end

    // push: tens and units
    always_comb begin
        n_tens  = dec_digit({5'b0, r2_rem}, 12'd10);
        n_units = {5'b0, r2_rem} - 12'(16'(n_tens) * 16'd10);
        o_item.status = r2_status;
        o_item.thous  = r2_thous;
        o_item.hunds  = r2_hunds;
        o_item.tens   = n_tens;
        o_item.units  = n_units[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r1_valid <= i_valid;
            end
            if (s2_ready) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r1_status <= n1_status;
            r1_thous  <= n1_thous;
            r1_rem    <= n1_rem[9:0];
        end
        if (s2_ready && r1_valid) begin
            r2_status <= r1_status;
            r2_thous  <= r1_thous;
            r2_hunds  <= n2_hunds;
            r2_rem    <= n2_rem[6:0];
        end
    end

endmodule

// ===== rtl/core/irn_queue.sv =====
module irn_queue
    import irn_pkg::*;
#(
    parameter int Depth = IRN_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_push_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_item            r_slot [Depth];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_push_ready = (r_count != CntW'(Depth));
    assign o_valid      = (r_count != '0);
    assign wr_en        = i_push && o_push_ready;
    assign rd_en        = i_pop && o_valid;
    assign o_item       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr] <= i_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("queue count overflow");

endmodule

// ===== rtl/core/irn_back.sv =====
module irn_back
    import irn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char_code,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic       r_busy;
    logic [1:0] r_status;
    logic [3:0] r_mask;
    logic [1:0] r_idx;
    logic [3:0] r_dig [4];

    logic       r_o_valid;
    logic [7:0] r_o_char;
    logic [1:0] r_o_status;
    logic       r_o_last;

    logic       out_free;
    logic       emit;
    logic       pop;
    logic [1:0] cur_pos;
    logic [3:0] cur_d;
    logic [2:0] cur_len;
    logic       dig_done;
    logic [3:0] rest;
    logic       last;
    logic [7:0] n_char;

    always_comb begin
        if (r_mask[3]) begin
            cur_pos = POS_THOUS;
        end else if (r_mask[2]) begin
            cur_pos = POS_HUNDS;
        end else if (r_mask[1]) begin
            cur_pos = POS_TENS;
        end else begin
            cur_pos = POS_UNITS;
        end
        cur_d    = r_dig[cur_pos];
        cur_len  = pat_len(cur_d);
        dig_done = ({1'b0, r_idx} + 3'd1) == cur_len;
        rest     = r_mask & ~(4'b0001 << cur_pos);
        last     = (r_status != ST_CHAR) || (dig_done && rest == 4'b0000);
        n_char   = (r_status == ST_CHAR) ? letter(cur_pos, pat_sym(cur_d, r_idx)) : 8'h00;
    end

    assign out_free = !r_o_valid || i_ready;
    assign emit     = r_busy && out_free;
    assign pop      = i_q_valid && (!r_busy || (emit && last));
    assign o_q_pop  = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_status <= i_item.status;
            r_idx    <= 2'd0;
            r_dig[3] <= {2'b00, i_item.thous};
            r_dig[2] <= i_item.hunds;
            r_dig[1] <= i_item.tens;
            r_dig[0] <= i_item.units;
            if (i_item.status == ST_CHAR) begin
                r_mask <= {i_item.thous != 2'd0, i_item.hunds != 4'd0,
                           i_item.tens != 4'd0, i_item.units != 4'd0};
            end else begin
                r_mask <= 4'b0000;
            end
        end else if (emit) begin
            if (dig_done) begin
                r_mask <= rest;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
        if (emit) begin
            r_o_char   <= n_char;
            r_o_status <= r_status;
            r_o_last   <= last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_status    = r_o_status;
    assign o_last      = r_o_last;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_status != ST_CHAR |-> r_o_last)
        else $error("status result not marked last");

    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_status == ST_CHAR |-> r_o_char != 8'h00)
        else $error("empty letter emitted");

    a_busy_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_status == ST_CHAR |-> r_mask != 4'b0000)
        else $error("encoding run with no digits left");

endmodule

// ===== rtl/core/integer_to_roman_numeral_core.sv =====
// Path: the first letter reaches o_valid through two digit-split stages, the queue
// write, the back-end load and the output register.
// Output: a numeral goes out one letter per transfer (1..15 letters); a zero or
// out-of-range value gives a single status result; the output port sets the pace.
// Reset: i_rst_n synchronous, active low; clears all valid flags, queue pointers
// and the back-end busy flag. Payload registers are not reset.
module integer_to_roman_numeral_core
    import irn_pkg::*;
#(
    parameter int QueueDepth = IRN_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char_code,
    output logic [1:0]  o_status,
    output logic        o_last
);

    // Front end: classify (zero / above 3999 / encodable), split into decimal digits
    // by parallel compare-and-subtract: thousands, hundreds, then tens with units.
    logic  f_push;
    logic  f_push_ready;
    t_item f_item;

    // Back end side of the queue
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    irn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_push       (f_push),
        .i_push_ready (f_push_ready),
        .o_item       (f_item)
    );

    // Short queue of classified items; lets the front keep taking values
    // while the back end is busy spelling out a long numeral.
    irn_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .o_push_ready (f_push_ready),
        .i_item       (f_item),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_item       (q_item)
    );

    // Back end: walks the nonzero digits from thousands down, one letter per
    // transfer, into an output register (a zero or out-of-range item gives one status
    // result); loads the next item on the same edge that its final letter is registered.
    irn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_item      (q_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ===== tb/tb_integer_to_roman_numeral_core.sv =====
`timescale 1ns / 1ps

module tb_integer_to_roman_numeral_core;
    import irn_pkg::*;

    // Watchdog bound. The slowest legal run is 170 values of up to 15 letters each,
    // every letter possibly held up by sink stalls, plus source gaps, so this bound
    // leaves a wide margin.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;     // extra wait after the scoreboard drains
    localparam int RANDOM_ITEMS = 145;

    // One expected output letter (or one status-only result).
    typedef struct packed {
        logic [7:0] char_code;
        logic [1:0] status;
        logic       is_last;
    } t_roman_letter;

    // Scoreboard: spells each accepted value into letters and matches output transfers
    // against them in order.
    class roman_scoreboard;
        t_roman_letter pending[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Expand one accepted value into the letters the core should emit.
        function void note_value(input logic [11:0] value);
            logic [7:0]    ones [4];
            logic [7:0]    fives[4];
            logic [7:0]    tens [4];
            int            scale[4];
            logic [7:0]    spelled[$];
            t_roman_letter entry;
            int            digit;

            ones  = '{ASCII_I, ASCII_X, ASCII_C, ASCII_M};
            fives = '{ASCII_V, ASCII_L, ASCII_D, ASCII_M};
            tens  = '{ASCII_X, ASCII_C, ASCII_M, ASCII_M};
            scale = '{1, 10, 100, 1000};

            if (value == 12'd0 || value > ROMAN_LIMIT) begin
                entry.char_code = 8'h00;
                entry.status    = (value == 12'd0) ? ST_ZERO : ST_RANGE;
                entry.is_last   = 1'b1;
                pending.push_back(entry);
                return;
            end

            // Thousands first, down to units.
            for (int p = 3; p >= 0; p--) begin
                digit = (int'(value) / scale[p]) % 10;
                case (digit)
                    1, 2, 3: begin
                        repeat (digit) spelled.push_back(ones[p]);
                    end
                    4: begin
                        spelled.push_back(ones[p]);
                        spelled.push_back(fives[p]);
                    end
                    5, 6, 7, 8: begin
                        spelled.push_back(fives[p]);
                        repeat (digit - 5) spelled.push_back(ones[p]);
                    end
                    9: begin
                        spelled.push_back(ones[p]);
                        spelled.push_back(tens[p]);
                    end
                    default: ;
                endcase
            end

            for (int k = 0; k < spelled.size(); k++) begin
                entry.char_code = spelled[k];
                entry.status    = ST_CHAR;
                entry.is_last   = (k == spelled.size() - 1);
                pending.push_back(entry);
            end
        endfunction

        function void check_letter(input logic [7:0] char_code, input logic [1:0] status,
                                   input logic is_last);
            t_roman_letter want;
            if (pending.size() == 0) begin
                $error("unexpected result: char_code %h status %0d last %0b",
                       char_code, status, is_last);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (char_code !== want.char_code) begin
                $error("char_code mismatch: expected %h, actual %h", want.char_code, char_code);
                mismatches++;
            end
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (is_last !== want.is_last) begin
                $error("last mismatch: expected %0b, actual %0b", want.is_last, is_last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [11:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_char_code;
    logic [1:0]  o_status;
    logic        o_last;

    roman_scoreboard ledger = new();

    int cycle_count = 0;

    // Sink stall pattern state.
    int unsigned sink_mode = 0;
    int unsigned sink_tick = 0;
    int unsigned sink_hold = 0;

    integer_to_roman_numeral_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // 2 ns period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Present one value and hold it until the input transfer completes.
    // Valid stays high going into the next call, so a burst runs back to back.
    task automatic send_value(input logic [11:0] value);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        ledger.note_value(value);
    endtask

    // Source stall: valid low for a number of cycles.
    task automatic hold_off_source(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Sink ready pattern, switching at intervals to a randomly picked style:
    //   0: always ready
    //   1: coin flip each cycle
    //   2: drops one cycle in four
    //   3: mostly ready, with occasional long stalls
    // Styles 0 and 3 give long stretches with no sink stall.
    always @(negedge i_clk) begin
        logic next_ready;
        sink_tick = sink_tick + 1;
        if (sink_tick % 97 == 0) sink_mode = $urandom_range(0, 3);
        case (sink_mode)
            0: next_ready = 1'b1;
            1: next_ready = 1'($urandom_range(0, 1));
            2: next_ready = (sink_tick % 4 != 0);
            default: begin
                if (sink_hold > 0) begin
                    sink_hold  = sink_hold - 1;
                    next_ready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    sink_hold  = $urandom_range(5, 20);
                    next_ready = 1'b0;
                end else begin
                    next_ready = 1'b1;
                end
            end
        endcase
        i_ready <= next_ready;
    end

    // Output monitor. Sampling at the rising edge reads pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            ledger.check_letter(o_char_code, o_status, o_last);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [11:0] stim[$];
        int unsigned burst;
        int unsigned pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;

        // Directed values:
        //   - zero and the out-of-range band, including all-ones
        //   - every digit shape in the units position
        //   - the subtractive forms in the tens and hundreds positions
        //   - the longest numeral and the top legal value
        stim = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7, 12'd8, 12'd9,
                 12'd10, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd3000, 12'd3888,
                 12'd3999, 12'd4000, 12'd4095, 12'd1994, 12'd2444, 12'd1666, 12'd2049};

        // Random values. Most are legal; some are weighted toward long numerals
        // (3000s), and the rest cover zero, out-of-range and the full 12-bit span.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       stim.push_back(12'd0);
                1:       stim.push_back(12'($urandom_range(4000, 4095)));
                2:       stim.push_back(12'($urandom_range(0, 4095)));
                3, 4:    stim.push_back(12'($urandom_range(3000, 3999)));
                default: stim.push_back(12'($urandom_range(1, 3999)));
            endcase
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Source in bursts; about a quarter of the bursts run straight into the next.
        while (stim.size() > 0) begin
            burst = $urandom_range(1, 10);
            while (burst > 0 && stim.size() > 0) begin
                send_value(stim.pop_front());
                burst--;
            end
            if ($urandom_range(0, 3) != 0) hold_off_source($urandom_range(1, 8));
        end
        hold_off_source(1);

        // Drain, then give late or extra letters time to show up.
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
